>>> src/csdb_pkg.sv
package csdb_pkg;

  localparam int unsigned STORE_DEPTH      = 1024;
  localparam int unsigned STORE_AW         = $clog2(STORE_DEPTH);
  localparam int unsigned USED_W           = STORE_AW + 1;
  localparam int unsigned MAX_STACK_FRAMES = 128;
  localparam int unsigned STAGE_AW         = $clog2(MAX_STACK_FRAMES);
  localparam int unsigned LEN_W            = 8;
  localparam int unsigned ADDR_W           = 64;
  localparam int unsigned COUNT_W          = 8;
  localparam int unsigned INDEX_W          = 10;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'd255;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_STAGED   = 3'd0,
    ST_INCR     = 3'd1,
    ST_APPENDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_READ     = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_IGNORED  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_C,
    S_CMP_A,
    S_CMP_C,
    S_DECIDE,
    S_INC,
    S_CLR,
    S_APP_A,
    S_APP_C,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    SEL_READ,
    SEL_SCAN,
    SEL_CMP,
    SEL_HIT
  } sel_e;

  typedef struct packed {
    logic accept;
    logic store_re;
    sel_e sel;
    logic stage_re;
    logic scan_start;
    logic scan_next;
    logic cmp_start;
    logic cmp_next;
    logic hit_rec;
    logic inc_wr;
    logic app_start;
    logic app_wr;
    logic app_done;
    logic set_pending;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic pending;
    logic out_free;
    logic used_ge;
    logic cand_ok;
    logic end_hit;
    logic k_eq_len;
    logic step_ok;
    logic term_ok;
    logic found;
    logic fits;
  } stat_t;

endpackage

>>> src/call_stack_sample_dedup_buffer.sv
// Flow: a frame that does not end a stack, a read or an ignored word goes straight to its
// registered result word; a clear first appends the frames of a pending stack that fits.
// A final frame scans each stored entry and compares the frames of each candidate, then
// counts a hit, appends the staged frames or reports full; one word is in flight at a time.
// Reset is asynchronous and active low; it empties the store by its fill count and sets
// sampling enabled; store memory contents are not cleared.
module call_stack_sample_dedup_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [csdb_pkg::ADDR_W-1:0]   frame_address_i,
  input  logic                          last_frame_i,
  input  logic [csdb_pkg::INDEX_W-1:0]  read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [csdb_pkg::INDEX_W-1:0]  entry_index_o,
  output logic [csdb_pkg::ADDR_W-1:0]   entry_address_o,
  output logic [csdb_pkg::COUNT_W-1:0]  entry_count_o,
  output logic [csdb_pkg::USED_W-1:0]   used_length_o,
  output logic [csdb_pkg::ADDR_W-1:0]   range_low_o,
  output logic [csdb_pkg::ADDR_W-1:0]   range_high_o
);

  csdb_pkg::cmd_t  cmd;
  csdb_pkg::stat_t stat;

  csdb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .opcode_i     (opcode_i),
    .last_frame_i (last_frame_i),
    .stat_i       (stat),
    .in_stall_o   (in_stall_o),
    .cmd_o        (cmd)
  );

  csdb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .frame_address_i (frame_address_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .entry_address_o (entry_address_o),
    .entry_count_o   (entry_count_o),
    .used_length_o   (used_length_o),
    .range_low_o     (range_low_o),
    .range_high_o    (range_high_o)
  );

endmodule

>>> src/csdb_ram.sv
module csdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/csdb_ctrl.sv
module csdb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            opcode_i,
  input  logic                  last_frame_i,
  input  csdb_pkg::stat_t       stat_i,
  output logic                  in_stall_o,
  output csdb_pkg::cmd_t        cmd_o
);

  csdb_pkg::state_e state_q, state_d;
  logic accept;

  assign in_stall_o = !((state_q == csdb_pkg::S_IDLE) && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csdb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      csdb_pkg::S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            csdb_pkg::OP_FRAME: begin
              if (stat_i.enabled && !stat_i.pending && last_frame_i) begin
                state_d = csdb_pkg::S_SCAN_A;
              end else begin
                state_d = csdb_pkg::S_OUT;
              end
            end
            csdb_pkg::OP_CLEAR: state_d = csdb_pkg::S_CLR;
            default:            state_d = csdb_pkg::S_OUT;
          endcase
        end
      end
      csdb_pkg::S_SCAN_A: begin
        state_d = stat_i.used_ge ? csdb_pkg::S_DECIDE : csdb_pkg::S_SCAN_C;
      end
      csdb_pkg::S_SCAN_C: begin
        state_d = stat_i.cand_ok ? csdb_pkg::S_CMP_A : csdb_pkg::S_SCAN_A;
      end
      csdb_pkg::S_CMP_A: begin
        if (stat_i.k_eq_len && stat_i.end_hit) begin
          state_d = csdb_pkg::S_SCAN_A;
        end else begin
          state_d = csdb_pkg::S_CMP_C;
        end
      end
      csdb_pkg::S_CMP_C: begin
        if (!stat_i.k_eq_len && stat_i.step_ok) begin
          state_d = csdb_pkg::S_CMP_A;
        end else begin
          state_d = csdb_pkg::S_SCAN_A;
        end
      end
      csdb_pkg::S_DECIDE: begin
        if (stat_i.found) begin
          state_d = csdb_pkg::S_INC;
        end else if (stat_i.fits) begin
          state_d = csdb_pkg::S_APP_A;
        end else begin
          state_d = csdb_pkg::S_OUT;
        end
      end
      csdb_pkg::S_INC: state_d = csdb_pkg::S_OUT;
      csdb_pkg::S_CLR: begin
        state_d = (stat_i.pending && stat_i.fits) ? csdb_pkg::S_APP_A : csdb_pkg::S_OUT;
      end
      csdb_pkg::S_APP_A: begin
        state_d = stat_i.k_eq_len ? csdb_pkg::S_OUT : csdb_pkg::S_APP_C;
      end
      csdb_pkg::S_APP_C: state_d = csdb_pkg::S_APP_A;
      csdb_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          state_d = csdb_pkg::S_IDLE;
        end
      end
      default: state_d = csdb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.sel    = csdb_pkg::SEL_READ;
    cmd_o.accept = accept;
    case (state_q)
      csdb_pkg::S_IDLE: begin
        if (accept && (opcode_i == csdb_pkg::OP_READ)) begin
          cmd_o.store_re = 1'b1;
        end
        if (accept && (opcode_i == csdb_pkg::OP_FRAME) && stat_i.enabled &&
            !stat_i.pending && last_frame_i) begin
          cmd_o.scan_start = 1'b1;
        end
      end
      csdb_pkg::S_SCAN_A: begin
        if (!stat_i.used_ge) begin
          cmd_o.store_re = 1'b1;
          cmd_o.sel      = csdb_pkg::SEL_SCAN;
        end
      end
      csdb_pkg::S_SCAN_C: begin
        if (stat_i.cand_ok) begin
          cmd_o.cmp_start = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      csdb_pkg::S_CMP_A: begin
        if (stat_i.k_eq_len && stat_i.end_hit) begin
          cmd_o.hit_rec   = 1'b1;
          cmd_o.scan_next = 1'b1;
        end else begin
          cmd_o.store_re = 1'b1;
          cmd_o.stage_re = 1'b1;
          cmd_o.sel      = csdb_pkg::SEL_CMP;
        end
      end
      csdb_pkg::S_CMP_C: begin
        if (stat_i.k_eq_len) begin
          cmd_o.hit_rec   = stat_i.term_ok;
          cmd_o.scan_next = 1'b1;
        end else if (stat_i.step_ok) begin
          cmd_o.cmp_next = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      csdb_pkg::S_DECIDE: begin
        if (stat_i.found) begin
          cmd_o.store_re = 1'b1;
          cmd_o.sel      = csdb_pkg::SEL_HIT;
        end else if (stat_i.fits) begin
          cmd_o.app_start = 1'b1;
        end else begin
          cmd_o.set_pending = 1'b1;
        end
      end
      csdb_pkg::S_INC: cmd_o.inc_wr = 1'b1;
      csdb_pkg::S_CLR: cmd_o.app_start = stat_i.pending && stat_i.fits;
      csdb_pkg::S_APP_A: begin
        if (stat_i.k_eq_len) begin
          cmd_o.app_done = 1'b1;
        end else begin
          cmd_o.stage_re = 1'b1;
        end
      end
      csdb_pkg::S_APP_C: cmd_o.app_wr = 1'b1;
      csdb_pkg::S_OUT:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> src/csdb_dp.sv
module csdb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csdb_pkg::cmd_t                cmd_i,
  output csdb_pkg::stat_t               stat_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [1:0]                    opcode_i,
  input  logic [csdb_pkg::ADDR_W-1:0]   frame_address_i,
  input  logic [csdb_pkg::INDEX_W-1:0]  read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [csdb_pkg::INDEX_W-1:0]  entry_index_o,
  output logic [csdb_pkg::ADDR_W-1:0]   entry_address_o,
  output logic [csdb_pkg::COUNT_W-1:0]  entry_count_o,
  output logic [csdb_pkg::USED_W-1:0]   used_length_o,
  output logic [csdb_pkg::ADDR_W-1:0]   range_low_o,
  output logic [csdb_pkg::ADDR_W-1:0]   range_high_o
);

  logic                          enabled_q, enabled_d;
  logic                          pending_q, pending_d;
  logic                          found_q, found_d;
  logic                          out_valid_q, out_valid_d;
  logic [csdb_pkg::USED_W-1:0]   used_q, used_d;
  logic [csdb_pkg::USED_W-1:0]   i_q, i_d;
  logic [csdb_pkg::LEN_W-1:0]    len_q, len_d;
  logic [csdb_pkg::LEN_W-1:0]    k_q, k_d;
  logic [csdb_pkg::STORE_AW-1:0] hit_q, hit_d;
  logic [csdb_pkg::ADDR_W-1:0]   low_q, low_d;
  logic [csdb_pkg::ADDR_W-1:0]   high_q, high_d;
  csdb_pkg::status_e             res_status_q, res_status_d;
  logic [csdb_pkg::INDEX_W-1:0]  res_index_q, res_index_d;

  logic [2:0]                    o_status_q;
  logic [csdb_pkg::INDEX_W-1:0]  o_index_q;
  logic [csdb_pkg::ADDR_W-1:0]   o_addr_q;
  logic [csdb_pkg::COUNT_W-1:0]  o_count_q;
  logic [csdb_pkg::USED_W-1:0]   o_used_q;
  logic [csdb_pkg::ADDR_W-1:0]   o_low_q;
  logic [csdb_pkg::ADDR_W-1:0]   o_high_q;

  logic [csdb_pkg::STORE_AW-1:0] store_raddr;
  logic [csdb_pkg::STORE_AW-1:0] count_waddr;
  logic [csdb_pkg::COUNT_W-1:0]  count_wdata;
  logic [csdb_pkg::ADDR_W-1:0]   frame_rdata;
  logic [csdb_pkg::ADDR_W-1:0]   stage_rdata;
  logic [csdb_pkg::COUNT_W-1:0]  count_rdata;
  logic                          stage_we;
  logic [csdb_pkg::USED_W:0]     pos_end;
  logic [csdb_pkg::USED_W:0]     used_end;
  logic [csdb_pkg::USED_W:0]     cmp_pos;
  logic                          frame_ok;
  logic                          out_free;

  assign pos_end  = {1'b0, i_q} + {{(csdb_pkg::USED_W + 1 - csdb_pkg::LEN_W){1'b0}}, len_q};
  assign used_end = {1'b0, used_q} + {{(csdb_pkg::USED_W + 1 - csdb_pkg::LEN_W){1'b0}}, len_q};
  assign cmp_pos  = {1'b0, i_q} + {{(csdb_pkg::USED_W + 1 - csdb_pkg::LEN_W){1'b0}}, k_q};
  assign frame_ok = enabled_q && !pending_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign stage_we = cmd_i.accept && (opcode_i == csdb_pkg::OP_FRAME) && frame_ok &&
                    (len_q < csdb_pkg::LEN_W'(csdb_pkg::MAX_STACK_FRAMES));

  always_comb begin
    case (cmd_i.sel)
      csdb_pkg::SEL_READ: store_raddr = read_index_i;
      csdb_pkg::SEL_SCAN: store_raddr = i_q[csdb_pkg::STORE_AW-1:0];
      csdb_pkg::SEL_CMP:  store_raddr = cmp_pos[csdb_pkg::STORE_AW-1:0];
      default:            store_raddr = hit_q;
    endcase
    if (cmd_i.inc_wr) begin
      count_waddr = hit_q;
      count_wdata = count_rdata + 1'b1;
    end else begin
      count_waddr = used_q[csdb_pkg::STORE_AW-1:0];
      count_wdata = (k_q == '0) ? csdb_pkg::COUNT_W'(1) : '0;
    end
  end

  csdb_ram #(.WIDTH(csdb_pkg::ADDR_W), .DEPTH(csdb_pkg::STORE_DEPTH)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.app_wr),
    .waddr_i (used_q[csdb_pkg::STORE_AW-1:0]),
    .wdata_i (stage_rdata),
    .re_i    (cmd_i.store_re),
    .raddr_i (store_raddr),
    .rdata_o (frame_rdata)
  );

  csdb_ram #(.WIDTH(csdb_pkg::COUNT_W), .DEPTH(csdb_pkg::STORE_DEPTH)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.app_wr || cmd_i.inc_wr),
    .waddr_i (count_waddr),
    .wdata_i (count_wdata),
    .re_i    (cmd_i.store_re),
    .raddr_i (store_raddr),
    .rdata_o (count_rdata)
  );

  csdb_ram #(.WIDTH(csdb_pkg::ADDR_W), .DEPTH(csdb_pkg::MAX_STACK_FRAMES)) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (stage_we),
    .waddr_i (len_q[csdb_pkg::STAGE_AW-1:0]),
    .wdata_i (frame_address_i),
    .re_i    (cmd_i.stage_re),
    .raddr_i (k_q[csdb_pkg::STAGE_AW-1:0]),
    .rdata_o (stage_rdata)
  );

  always_comb begin
    enabled_d    = cfg_we_i ? cfg_wdata_i : enabled_q;
    pending_d    = pending_q;
    found_d      = found_q;
    used_d       = used_q;
    i_d          = i_q;
    len_d        = len_q;
    k_d          = k_q;
    hit_d        = hit_q;
    low_d        = low_q;
    high_d       = high_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;

    if (stage_we) begin
      len_d = len_q + 1'b1;
    end
    if (cmd_i.accept) begin
      res_index_d = '0;
      case (opcode_i)
        csdb_pkg::OP_FRAME: begin
          res_status_d = frame_ok ? csdb_pkg::ST_STAGED : csdb_pkg::ST_IGNORED;
        end
        csdb_pkg::OP_READ: begin
          if ({1'b0, read_index_i} < used_q) begin
            res_status_d = csdb_pkg::ST_READ;
            res_index_d  = read_index_i;
          end else begin
            res_status_d = csdb_pkg::ST_IGNORED;
          end
        end
        csdb_pkg::OP_CLEAR: begin
          res_status_d = csdb_pkg::ST_CLEARED;
          used_d       = '0;
          low_d        = '1;
          high_d       = '0;
        end
        default: res_status_d = csdb_pkg::ST_IGNORED;
      endcase
    end
    if (cmd_i.scan_start) begin
      i_d     = '0;
      found_d = 1'b0;
    end
    if (cmd_i.scan_next) begin
      i_d = i_q + 1'b1;
    end
    if (cmd_i.cmp_start || cmd_i.app_start) begin
      k_d = '0;
    end
    if (cmd_i.cmp_next || cmd_i.app_wr) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.hit_rec) begin
      found_d = 1'b1;
      hit_d   = i_q[csdb_pkg::STORE_AW-1:0];
    end
    if (cmd_i.inc_wr) begin
      len_d        = '0;
      res_status_d = csdb_pkg::ST_INCR;
      res_index_d  = hit_q;
    end
    if (cmd_i.set_pending) begin
      pending_d    = 1'b1;
      res_status_d = csdb_pkg::ST_FULL;
    end
    if (cmd_i.app_start) begin
      res_index_d = used_q[csdb_pkg::INDEX_W-1:0];
      if (res_status_q == csdb_pkg::ST_STAGED) begin
        res_status_d = csdb_pkg::ST_APPENDED;
      end
    end
    if (cmd_i.app_wr) begin
      used_d = used_q + 1'b1;
      if (stage_rdata < low_q) begin
        low_d = stage_rdata;
      end
      if (stage_rdata > high_q) begin
        high_d = stage_rdata;
      end
    end
    if (cmd_i.app_done) begin
      len_d     = '0;
      pending_d = 1'b0;
    end
  end

  assign out_valid_d = cmd_i.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b1;
      pending_q    <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      used_q       <= '0;
      i_q          <= '0;
      len_q        <= '0;
      k_q          <= '0;
      hit_q        <= '0;
      low_q        <= '1;
      high_q       <= '0;
      res_status_q <= csdb_pkg::ST_IGNORED;
      res_index_q  <= '0;
    end else begin
      enabled_q    <= enabled_d;
      pending_q    <= pending_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      used_q       <= used_d;
      i_q          <= i_d;
      len_q        <= len_d;
      k_q          <= k_d;
      hit_q        <= hit_d;
      low_q        <= low_d;
      high_q       <= high_d;
      res_status_q <= res_status_d;
      res_index_q  <= res_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_status_q <= res_status_q;
      o_index_q  <= res_index_q;
      o_addr_q   <= (res_status_q == csdb_pkg::ST_READ) ? frame_rdata : '0;
      o_count_q  <= (res_status_q == csdb_pkg::ST_READ) ? count_rdata : '0;
      o_used_q   <= used_q;
      o_low_q    <= low_q;
      o_high_q   <= high_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign entry_index_o   = o_index_q;
  assign entry_address_o = o_addr_q;
  assign entry_count_o   = o_count_q;
  assign used_length_o   = o_used_q;
  assign range_low_o     = o_low_q;
  assign range_high_o    = o_high_q;

  always_comb begin
    stat_o          = '0;
    stat_o.enabled  = enabled_q;
    stat_o.pending  = pending_q;
    stat_o.out_free = out_free;
    stat_o.used_ge  = (i_q >= used_q);
    stat_o.cand_ok  = (count_rdata != '0) && (count_rdata != csdb_pkg::COUNT_LIMIT) &&
                      (pos_end <= {1'b0, used_q});
    stat_o.end_hit  = (pos_end == {1'b0, used_q});
    stat_o.k_eq_len = (k_q == len_q);
    stat_o.step_ok  = (frame_rdata == stage_rdata) && ((k_q == '0) || (count_rdata == '0));
    stat_o.term_ok  = (count_rdata != '0);
    stat_o.found    = found_q;
    stat_o.fits     = (used_end <= (csdb_pkg::USED_W + 1)'(csdb_pkg::STORE_DEPTH));
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= csdb_pkg::USED_W'(csdb_pkg::STORE_DEPTH))
    else $error("store fill count beyond depth");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= csdb_pkg::LEN_W'(csdb_pkg::MAX_STACK_FRAMES))
    else $error("staged length beyond frame limit");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (len_q != '0))
    else $error("pending stack without staged frames");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result word lost on load");

endmodule

>>> tb/sv/tb_call_stack_sample_dedup_buffer.sv
`timescale 1ns / 100ps

module tb_call_stack_sample_dedup_buffer;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int IDLE_PCT = 19;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] addr;
    logic        last;
    logic [9:0]  ridx;
  } word_t;

  typedef struct {
    logic [2:0]  status;
    logic [9:0]  index;
    logic [63:0] raddr;
    logic [7:0]  rcount;
    logic [10:0] used;
    logic [63:0] low;
    logic [63:0] high;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [63:0] frame_address = '0;
  logic last_frame = 1'b0;
  logic [9:0] read_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [9:0] entry_index;
  logic [63:0] entry_address;
  logic [7:0] entry_count;
  logic [10:0] used_length;
  logic [63:0] range_low;
  logic [63:0] range_high;

  call_stack_sample_dedup_buffer dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .opcode_i(opcode),
    .frame_address_i(frame_address), .last_frame_i(last_frame), .read_index_i(read_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .entry_index_o(entry_index), .entry_address_o(entry_address),
    .entry_count_o(entry_count), .used_length_o(used_length),
    .range_low_o(range_low), .range_high_o(range_high)
  );

  always #6 clk = ~clk;

  word_t words_to_send[$];
  answer_t answers_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_appended = 0;
  int n_folded = 0;
  int n_full = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  logic [63:0] m_frames[csdb_pkg::STORE_DEPTH];
  logic [7:0]  m_counts[csdb_pkg::STORE_DEPTH];
  logic [63:0] m_stage[csdb_pkg::MAX_STACK_FRAMES];
  int          m_used = 0;
  int          m_slen = 0;
  logic [63:0] m_low = '1;
  logic [63:0] m_high = '0;
  bit          m_pending = 1'b0;
  bit          m_enabled = 1'b1;

  function automatic bit stack_matches(int pos);
    if (pos + m_slen > m_used) return 1'b0;
    for (int k = 0; k < m_slen; k++) begin
      if (m_frames[pos + k] != m_stage[k]) return 1'b0;
      if (k > 0 && m_counts[pos + k] != 0) return 1'b0;
    end
    return (pos + m_slen == m_used) || (m_counts[pos + m_slen] != 0);
  endfunction

  task automatic append_stack(output bit ok, output int first);
    ok = 1'b0;
    first = 0;
    if (m_used + m_slen <= csdb_pkg::STORE_DEPTH) begin
      ok = 1'b1;
      first = m_used;
      for (int k = 0; k < m_slen; k++) begin
        m_frames[m_used] = m_stage[k];
        m_counts[m_used] = (k == 0) ? 8'd1 : 8'd0;
        if (m_stage[k] < m_low) m_low = m_stage[k];
        if (m_stage[k] > m_high) m_high = m_stage[k];
        m_used++;
      end
      m_slen = 0;
    end
  endtask

  task automatic predict_answer(input word_t w);
    answer_t a;
    bit found;
    bit ok;
    int hit;
    int first;
    a = '{status: csdb_pkg::ST_IGNORED, index: '0, raddr: '0, rcount: '0, used: '0,
          low: '0, high: '0};
    found = 1'b0;
    hit = 0;
    first = 0;
    case (w.op)
      csdb_pkg::OP_FRAME: begin
        if (m_enabled && !m_pending) begin
          if (m_slen < csdb_pkg::MAX_STACK_FRAMES) begin
            m_stage[m_slen] = w.addr;
            m_slen++;
          end
          a.status = csdb_pkg::ST_STAGED;
          if (w.last) begin
            for (int i = 0; i < m_used; i++) begin
              if (m_counts[i] != 0 && m_counts[i] < csdb_pkg::COUNT_LIMIT &&
                  stack_matches(i)) begin
                found = 1'b1;
                hit = i;
              end
            end
            if (found) begin
              m_counts[hit] = m_counts[hit] + 8'd1;
              m_slen = 0;
              a.status = csdb_pkg::ST_INCR;
              a.index = hit[9:0];
            end else begin
              append_stack(ok, first);
              if (ok) begin
                a.status = csdb_pkg::ST_APPENDED;
                a.index = first[9:0];
              end else begin
                m_pending = 1'b1;
                a.status = csdb_pkg::ST_FULL;
              end
            end
          end
        end
      end
      csdb_pkg::OP_READ: begin
        if (w.ridx < m_used) begin
          a.status = csdb_pkg::ST_READ;
          a.index = w.ridx;
          a.raddr = m_frames[w.ridx];
          a.rcount = m_counts[w.ridx];
        end
      end
      csdb_pkg::OP_CLEAR: begin
        m_used = 0;
        m_low = '1;
        m_high = '0;
        a.status = csdb_pkg::ST_CLEARED;
        if (m_pending) begin
          append_stack(ok, first);
          if (ok) begin
            m_pending = 1'b0;
            a.index = first[9:0];
          end
        end
      end
      default: ;
    endcase
    a.used = m_used[10:0];
    a.low = m_low;
    a.high = m_high;
    answers_due.push_back(a);
  endtask

  function automatic bit quiet_stretch();
    return n_sent >= 100 && n_sent < 220;
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_answer('{op: opcode, addr: frame_address, last: last_frame, ridx: read_index});
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() > 0 &&
            (quiet_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
          opcode <= words_to_send[0].op;
          frame_address <= words_to_send[0].addr;
          last_frame <= words_to_send[0].last;
          read_index <= words_to_send[0].ridx;
          void'(words_to_send.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on word %0d: %s got %h expected %h", n_seen, field, got, want);
    errors++;
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("unexpected result word %0d", n_seen);
          errors++;
        end else begin
          answer_t a;
          a = answers_due.pop_front();
          if (status !== a.status) report("status", status, a.status);
          if (entry_index !== a.index) report("entry_index", entry_index, a.index);
          if (entry_address !== a.raddr) report("entry_address", entry_address, a.raddr);
          if (entry_count !== a.rcount) report("entry_count", entry_count, a.rcount);
          if (used_length !== a.used) report("used_length", used_length, a.used);
          if (range_low !== a.low) report("range_low", range_low, a.low);
          if (range_high !== a.high) report("range_high", range_high, a.high);
          if (a.status == csdb_pkg::ST_APPENDED) n_appended++;
          if (a.status == csdb_pkg::ST_INCR) n_folded++;
          if (a.status == csdb_pkg::ST_FULL) n_full++;
        end
        n_seen++;
      end
      out_stall <= (hold_left > 0) || (!quiet_stretch() && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!hold_done && n_sent >= 40) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  logic [63:0] pool[8];
  int n_gen = 0;

  task automatic add_word(input logic [1:0] op, input logic [63:0] addr, input logic last,
                          input logic [9:0] ridx);
    words_to_send.push_back('{op: op, addr: addr, last: last, ridx: ridx});
    n_gen++;
  endtask

  task automatic add_stack(input int len, input bit from_pool);
    logic [63:0] a;
    for (int k = 0; k < len; k++) begin
      a = from_pool ? pool[$urandom_range(7)] : {$urandom, $urandom};
      add_word(csdb_pkg::OP_FRAME, a, k == len - 1, 10'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (words_to_send.size() > 0 || answers_due.size() > 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_sampling(input bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_enabled = v;
  endtask

  initial begin
    int pick;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 8; i++) pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_sampling(1'b1);

    add_word(csdb_pkg::OP_FRAME, '0, 1'b1, '0);
    add_word(csdb_pkg::OP_FRAME, '0, 1'b1, '1);
    add_word(csdb_pkg::OP_FRAME, '1, 1'b0, '0);
    add_word(csdb_pkg::OP_FRAME, '0, 1'b0, '0);
    add_word(csdb_pkg::OP_FRAME, 64'd5, 1'b1, '0);
    add_word(csdb_pkg::OP_FRAME, '1, 1'b0, '0);
    add_word(csdb_pkg::OP_FRAME, '0, 1'b0, '0);
    add_word(csdb_pkg::OP_FRAME, 64'd5, 1'b1, '0);
    add_word(csdb_pkg::OP_FRAME, '1, 1'b0, '0);
    add_word(csdb_pkg::OP_FRAME, '0, 1'b1, '0);
    add_word(csdb_pkg::OP_READ, '0, 1'b0, 10'd0);
    add_word(csdb_pkg::OP_READ, '0, 1'b0, 10'd3);
    add_word(csdb_pkg::OP_READ, '1, 1'b1, 10'd1023);
    add_word(2'd3, '1, 1'b1, '1);
    add_word(csdb_pkg::OP_FRAME, 64'h1234, 1'b0, '0);
    add_word(csdb_pkg::OP_CLEAR, '0, 1'b0, '0);
    add_word(csdb_pkg::OP_READ, '0, 1'b0, 10'd0);
    add_word(csdb_pkg::OP_FRAME, 64'h99, 1'b1, '0);
    wait_drained();
    set_sampling(1'b0);
    add_word(csdb_pkg::OP_FRAME, 64'h7, 1'b0, '0);
    add_word(csdb_pkg::OP_FRAME, 64'h8, 1'b1, '0);
    add_word(csdb_pkg::OP_READ, '0, 1'b0, 10'd0);
    wait_drained();
    set_sampling(1'b1);

    n_gen = 0;
    while (n_gen < 110) begin
      pick = $urandom_range(99);
      if (pick < 68) add_stack($urandom_range(1, 6), 1'b1);
      else if (pick < 78) add_word(csdb_pkg::OP_READ, {$urandom, $urandom}, 1'($urandom),
                                   (pick < 74) ? 10'($urandom_range(0, 40)) : 10'($urandom));
      else if (pick < 82) add_word(csdb_pkg::OP_CLEAR, {$urandom, $urandom}, 1'($urandom),
                                   10'($urandom));
      else if (pick < 87) add_word(2'($urandom), {$urandom, $urandom}, 1'($urandom),
                                   10'($urandom));
      else if (pick < 89) add_stack($urandom_range(120, 140), 1'b0);
      else if (pick < 94) add_stack($urandom_range(1, 4), 1'b0);
      else begin
        add_stack($urandom_range(1, 3), 1'b1);
        void'(words_to_send.pop_back());
        n_gen--;
        add_word(csdb_pkg::OP_CLEAR, '0, 1'b0, '0);
      end
      if (n_gen > 60 && n_gen < 70) begin
        wait_drained();
        set_sampling(1'b0);
        add_stack(3, 1'b1);
        wait_drained();
        set_sampling(1'b1);
        n_gen = 70;
      end
    end

    add_word(csdb_pkg::OP_CLEAR, '0, 1'b0, '0);
    for (int r = 0; r < 260; r++) add_word(csdb_pkg::OP_FRAME, pool[2], 1'b1, '0);
    add_word(csdb_pkg::OP_READ, '0, 1'b0, 10'd0);
    add_word(csdb_pkg::OP_READ, '0, 1'b0, 10'd1);
    wait_drained();

    $display("%0d words sent, %0d results checked: %0d stacks appended, %0d folded, %0d full",
             n_sent, n_seen, n_appended, n_folded, n_full);
    $display("covered disabled sampling, clears of partly staged stacks, saturated counts");
    if (errors == 0 && answers_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/csdb_pkg.sv
src/csdb_ram.sv
src/csdb_ctrl.sv
src/csdb_dp.sv
src/call_stack_sample_dedup_buffer.sv
tb/sv/tb_call_stack_sample_dedup_buffer.sv
